>>> sv/nvpf_pkg.sv
`default_nettype none
package nvpf_pkg;

  localparam int unsigned NVPF_MAX_DIMENSION = 4096;

  // hash constants
  localparam logic [31:0] HASH_MUL_X     = 32'd73856093;
  localparam logic [31:0] HASH_MUL_Y     = 32'd19349663;
  localparam logic [31:0] HASH_MUL_FRAME = 32'd83492791;
  localparam logic [31:0] HASH_MIX       = 32'h5bd1e995;
  localparam logic [7:0]  GRAIN_MOD      = 8'd41;
  localparam logic [5:0]  GRAIN_OFFSET   = 6'd20;
  localparam logic [7:0]  DARK_MAX       = 8'd200;

  // register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRAME_NUMBER = 3'd2;
  localparam logic [2:0] REG_WEIGHT_RED   = 3'd3;
  localparam logic [2:0] REG_WEIGHT_GREEN = 3'd4;
  localparam logic [2:0] REG_WEIGHT_BLUE  = 3'd5;

  localparam logic [12:0] RST_IMAGE_WIDTH  = 13'd320;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd240;
  localparam logic [8:0]  RST_WEIGHT_RED   = 9'd77;
  localparam logic [8:0]  RST_WEIGHT_GREEN = 9'd150;
  localparam logic [8:0]  RST_WEIGHT_BLUE  = 9'd29;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;
    logic [8:0]  coverage;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pixel_out_t;

  // derived configuration seen by the pipeline
  typedef struct packed {
    logic [11:0] cx;
    logic [11:0] cy;
    logic [24:0] m2;
    logic [31:0] frame_mul;
    logic [8:0]  weight_red;
    logic [8:0]  weight_green;
    logic [8:0]  weight_blue;
  } cfg_t;

  // item data that rides along the divider
  typedef struct packed {
    logic [8:0]  base_r;
    logic [8:0]  base_g;
    logic [8:0]  base_b;
    logic [20:0] hfold;
    logic [7:0]  orig_r;
    logic [7:0]  orig_g;
    logic [7:0]  orig_b;
    logic [8:0]  cov;
  } carry_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [7:0]  quo;
    logic        sat;
  } div_t;

endpackage
`default_nettype wire

>>> sv/night_vision_pixel_filter.sv
`default_nettype none
// night-vision pixel filter: one pixel item in, one filtered and blended pixel out.
// an item is taken at every clock edge where start_i is high (busy_o stays low), and its
// result appears on result_o for one cycle with result_valid_o high, after a 4-stage front
// (luminance, hash, distance), 8 restoring divider stages that give one vignette quotient
// bit each, and a 6-stage back end (grain, darkening, blend). the receiver cannot stall, so
// every item flows through at one per clock. configuration goes through the apb port at
// byte address 4*index and must be written while no item is in flight; derived values
// (centre, radius squared, frame hash term) are registered from the configuration
// registers, radius squared from the registered centre.
module night_vision_pixel_filter #(
  parameter int unsigned MaxDimension = nvpf_pkg::NVPF_MAX_DIMENSION
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // item channel
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire nvpf_pkg::pixel_in_t pixel_i,
  output logic             result_valid_o,
  output nvpf_pkg::pixel_out_t result_o,
  // configuration port
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [4:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  import nvpf_pkg::*;

  localparam logic [11:0] RstCx = RST_IMAGE_WIDTH[12:1];
  localparam logic [11:0] RstCy = RST_IMAGE_HEIGHT[12:1];
  localparam logic [24:0] RstM2 = 25'(RstCx * RstCx) + 25'(RstCy * RstCy);
  localparam int unsigned NumDivSteps = 8;

  // configuration registers
  logic [12:0] width_q, height_q;
  logic [31:0] frame_q;
  logic [8:0]  wr_q, wg_q, wb_q;
  // derived registers
  logic [11:0] cx_q, cy_q, cx_d, cy_d;
  logic [24:0] m2_q, m2_d;
  logic [31:0] fmul_q;
  logic [12:0] width_sat, height_sat;
  logic        cfg_write;
  cfg_t        cfg;

  assign cfg_write = psel_i & penable_i & pwrite_i & pready_o;
  assign pready_o  = 1'b1;
  assign busy_o    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      frame_q  <= '0;
      wr_q     <= RST_WEIGHT_RED;
      wg_q     <= RST_WEIGHT_GREEN;
      wb_q     <= RST_WEIGHT_BLUE;
    end else if (cfg_write) begin
      unique case (paddr_i[4:2])
        REG_IMAGE_WIDTH:  width_q  <= pwdata_i[12:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata_i[12:0];
        REG_FRAME_NUMBER: frame_q  <= pwdata_i;
        REG_WEIGHT_RED:   wr_q     <= pwdata_i[8:0];
        REG_WEIGHT_GREEN: wg_q     <= pwdata_i[8:0];
        REG_WEIGHT_BLUE:  wb_q     <= pwdata_i[8:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr_i[4:2])
      REG_IMAGE_WIDTH:  prdata_o = 32'(width_q);
      REG_IMAGE_HEIGHT: prdata_o = 32'(height_q);
      REG_FRAME_NUMBER: prdata_o = frame_q;
      REG_WEIGHT_RED:   prdata_o = 32'(wr_q);
      REG_WEIGHT_GREEN: prdata_o = 32'(wg_q);
      REG_WEIGHT_BLUE:  prdata_o = 32'(wb_q);
      default:          prdata_o = '0;
    endcase
  end

  // oversized dimensions clamp, then the centre is half of it
  always_comb begin
    width_sat  = (32'(width_q) > MaxDimension) ? 13'(MaxDimension) : width_q;
    height_sat = (32'(height_q) > MaxDimension) ? 13'(MaxDimension) : height_q;
    cx_d = width_sat[12:1];
    cy_d = height_sat[12:1];
    // squared half diagonal, never zero so the divider always has a divisor
    m2_d = 25'(cx_q * cx_q) + 25'(cy_q * cy_q);
    if (m2_d == '0) begin
      m2_d = 25'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q   <= RstCx;
      cy_q   <= RstCy;
      m2_q   <= RstM2;
      fmul_q <= '0;
    end else begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      m2_q   <= m2_d;
      fmul_q <= 32'(frame_q * HASH_MUL_FRAME);
    end
  end

  assign cfg = '{cx: cx_q, cy: cy_q, m2: m2_q, frame_mul: fmul_q,
                 weight_red: wr_q, weight_green: wg_q, weight_blue: wb_q};

  // pipeline
  logic   vld_s [NumDivSteps+1];
  div_t   div_s [NumDivSteps+1];
  carry_t car_s [NumDivSteps+1];

  nvpf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i & ~busy_o),
    .pixel_i (pixel_i),
    .cfg_i   (cfg),
    .valid_o (vld_s[0]),
    .div_o   (div_s[0]),
    .carry_o (car_s[0])
  );

  // vignette divider, most significant quotient bit first
  for (genvar i = 0; i < NumDivSteps; i++) begin : g_div
    nvpf_div_step #(
      .Bit (NumDivSteps - 1 - i)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[i]),
      .div_i   (div_s[i]),
      .carry_i (car_s[i]),
      .m2_i    (m2_q),
      .valid_o (vld_s[i+1]),
      .div_o   (div_s[i+1]),
      .carry_o (car_s[i+1])
    );
  end

  nvpf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vld_s[NumDivSteps]),
    .div_i    (div_s[NumDivSteps]),
    .carry_i  (car_s[NumDivSteps]),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

>>> sv/nvpf_front.sv
`default_nettype none
module nvpf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire nvpf_pkg::pixel_in_t pixel_i,
  input  wire nvpf_pkg::cfg_t     cfg_i,
  output logic                    valid_o,
  output nvpf_pkg::div_t          div_o,
  output nvpf_pkg::carry_t        carry_o
);
  import nvpf_pkg::*;

  logic [3:0] vld_q;

  // stage 1
  logic [16:0] pr_q, pg_q, pb_q;
  logic [31:0] hx_q, hy_q, hf_q;
  logic signed [12:0] dx_q, dy_q;
  carry_t c1_q;
  // stage 2
  logic [8:0] r0_q, g0_q, b0_q;
  logic [31:0] h1_q;
  logic [23:0] dx2_q, dy2_q;
  carry_t c2_q;
  // stage 3
  logic [31:0] h2_q;
  logic [24:0] d2_q;
  carry_t c3_q, c3_d;
  // stage 4
  div_t div_q;
  carry_t c4_q, c4_d;

  logic [8:0] cov_sat;
  logic [18:0] lum_sum;
  logic [10:0] lum;
  logic [31:0] h0, h1, h3;
  logic signed [25:0] dx2_full, dy2_full;
  logic [20:0] v1;

  always_comb begin
    cov_sat = (pixel_i.coverage > 9'd256) ? 9'd256 : pixel_i.coverage;
    lum_sum = 19'(pr_q) + 19'(pg_q) + 19'(pb_q);
    lum = lum_sum[18:8];
    h0 = hx_q ^ hy_q ^ hf_q;
    h1 = h0 ^ (h0 >> 13);
    dx2_full = dx_q * dx_q;
    dy2_full = dy_q * dy_q;
    h3 = h2_q ^ (h2_q >> 15);
    v1 = 21'(h3[31:16]) * 21'd18 + 21'(h3[15:0]);
    c3_d = c2_q;
    c3_d.base_r = r0_q;
    c3_d.base_g = g0_q;
    c3_d.base_b = b0_q;
    c4_d = c3_q;
    c4_d.hfold = v1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q <= 17'(cfg_i.weight_red * pixel_i.in_red);
    pg_q <= 17'(cfg_i.weight_green * pixel_i.in_green);
    pb_q <= 17'(cfg_i.weight_blue * pixel_i.in_blue);
    hx_q <= 32'(32'(pixel_i.pixel_x) * HASH_MUL_X);
    hy_q <= 32'(32'(pixel_i.pixel_y) * HASH_MUL_Y);
    hf_q <= cfg_i.frame_mul;
    dx_q <= $signed({1'b0, pixel_i.pixel_x}) - $signed({1'b0, cfg_i.cx});
    dy_q <= $signed({1'b0, pixel_i.pixel_y}) - $signed({1'b0, cfg_i.cy});
    c1_q <= '{base_r: '0, base_g: '0, base_b: '0, hfold: '0,
              orig_r: pixel_i.in_red, orig_g: pixel_i.in_green,
              orig_b: pixel_i.in_blue, cov: cov_sat};

    r0_q <= 9'(lum >> 2);
    b0_q <= 9'(lum >> 2);
    g0_q <= (lum > 11'd127) ? 9'd255 : {1'b0, lum[6:0], 1'b0};
    h1_q <= h1;
    dx2_q <= dx2_full[23:0];
    dy2_q <= dy2_full[23:0];
    c2_q <= c1_q;

    h2_q <= 32'(h1_q * HASH_MIX);
    d2_q <= 25'(dx2_q) + 25'(dy2_q);
    c3_q <= c3_d;

    div_q <= '{rem: 34'(d2_q) * 34'd200, quo: '0, sat: (d2_q >= cfg_i.m2)};
    c4_q <= c4_d;
  end

  assign valid_o = vld_q[3];
  assign div_o   = div_q;
  assign carry_o = c4_q;
endmodule
`default_nettype wire

>>> sv/nvpf_div_step.sv
`default_nettype none
module nvpf_div_step #(
  parameter int unsigned Bit = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire nvpf_pkg::div_t  div_i,
  input  wire nvpf_pkg::carry_t carry_i,
  input  wire logic [24:0]     m2_i,
  output logic                 valid_o,
  output nvpf_pkg::div_t       div_o,
  output nvpf_pkg::carry_t     carry_o
);
  import nvpf_pkg::*;

  logic   vld_q;
  div_t   div_q, div_d;
  carry_t carry_q;
  logic [33:0] trial;

  // one restoring quotient bit
  assign trial = 34'(m2_i) << Bit;

  always_comb begin
    div_d = div_i;
    if (div_i.rem >= trial) begin
      div_d.rem = div_i.rem - trial;
      div_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    carry_q <= carry_i;
  end

  assign valid_o = vld_q;
  assign div_o   = div_q;
  assign carry_o = carry_q;
endmodule
`default_nettype wire

>>> sv/nvpf_back.sv
`default_nettype none
module nvpf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire nvpf_pkg::div_t  div_i,
  input  wire nvpf_pkg::carry_t carry_i,
  output logic                 valid_o,
  output nvpf_pkg::pixel_out_t result_o
);
  import nvpf_pkg::*;

  logic [5:0] vld_q;

  // stage 1
  logic [11:0] v3_q;
  logic [7:0]  dark_q;
  carry_t c1_q;
  // stage 2
  logic [7:0] v6_q;
  logic [7:0] dark2_q;
  carry_t c2_q;
  // stage 3
  logic [7:0] cr_q, cg_q, cb_q;
  logic [7:0] f_q;
  carry_t c3_q;
  // stage 4
  logic [7:0] fr_q, fg_q, fb_q;
  carry_t c4_q;
  // stage 5
  logic signed [18:0] pr_q, pg_q, pb_q;
  logic [7:0] or_q, og_q, ob_q;
  // stage 6
  pixel_out_t res_q;

  logic [15:0] v2;
  logic [11:0] v3;
  logic [10:0] v4;
  logic [8:0]  v5;
  logic [7:0]  v6;
  logic [7:0]  rmod;
  logic signed [5:0] grain;

  function automatic logic [7:0] add_clamp(input logic [8:0] c, input logic signed [5:0] d);
    logic signed [9:0] s;
    s = $signed({1'b0, c}) + 10'(d);
    if (s < 0) begin
      add_clamp = 8'd0;
    end else if (s > 10'sd255) begin
      add_clamp = 8'd255;
    end else begin
      add_clamp = s[7:0];
    end
  endfunction

  function automatic logic signed [18:0] mix_prod(input logic [7:0] filt, input logic [7:0] orig,
                                                  input logic [8:0] cov);
    logic signed [8:0] diff;
    diff = $signed({1'b0, filt}) - $signed({1'b0, orig});
    mix_prod = diff * $signed({1'b0, cov});
  endfunction

  function automatic logic [7:0] mix_out(input logic signed [18:0] prod, input logic [7:0] orig);
    logic signed [10:0] sum;
    sum = $signed({3'b000, orig}) + $signed(prod[18:8]);
    if (sum < 0) begin
      mix_out = 8'd0;
    end else if (sum > 11'sd255) begin
      mix_out = 8'd255;
    end else begin
      mix_out = sum[7:0];
    end
  endfunction

  // hash mod 41 by folding: 2^10 = 40 and 2^6 = 23 modulo 41
  always_comb begin
    v2 = 16'(carry_i.hfold[20:10]) * 16'd40 + 16'(carry_i.hfold[9:0]);
    v3 = 12'(12'(v2[15:10]) * 12'd40 + 12'(v2[9:0]));
    v4 = 11'(11'(v3_q[11:6]) * 11'd23 + 11'(v3_q[5:0]));
    v5 = 9'(9'(v4[10:6]) * 9'd23 + 9'(v4[5:0]));
    v6 = 8'(8'(v5[8:6]) * 8'd23 + 8'(v5[5:0]));
    if (v6_q >= 8'(5 * GRAIN_MOD)) begin
      rmod = v6_q - 8'(5 * GRAIN_MOD);
    end else if (v6_q >= 8'(4 * GRAIN_MOD)) begin
      rmod = v6_q - 8'(4 * GRAIN_MOD);
    end else if (v6_q >= 8'(3 * GRAIN_MOD)) begin
      rmod = v6_q - 8'(3 * GRAIN_MOD);
    end else if (v6_q >= 8'(2 * GRAIN_MOD)) begin
      rmod = v6_q - 8'(2 * GRAIN_MOD);
    end else if (v6_q >= GRAIN_MOD) begin
      rmod = v6_q - GRAIN_MOD;
    end else begin
      rmod = v6_q;
    end
    grain = $signed(rmod[5:0]) - $signed(GRAIN_OFFSET);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    v3_q   <= v3;
    dark_q <= div_i.sat ? DARK_MAX : div_i.quo;
    c1_q   <= carry_i;

    v6_q    <= v6;
    dark2_q <= dark_q;
    c2_q    <= c1_q;

    cr_q <= add_clamp(c2_q.base_r, grain);
    cg_q <= add_clamp(c2_q.base_g, grain);
    cb_q <= add_clamp(c2_q.base_b, grain);
    f_q  <= 8'd255 - dark2_q;
    c3_q <= c2_q;

    fr_q <= 8'((16'(cr_q) * 16'(f_q)) >> 8);
    fg_q <= 8'((16'(cg_q) * 16'(f_q)) >> 8);
    fb_q <= 8'((16'(cb_q) * 16'(f_q)) >> 8);
    c4_q <= c3_q;

    pr_q <= mix_prod(fr_q, c4_q.orig_r, c4_q.cov);
    pg_q <= mix_prod(fg_q, c4_q.orig_g, c4_q.cov);
    pb_q <= mix_prod(fb_q, c4_q.orig_b, c4_q.cov);
    or_q <= c4_q.orig_r;
    og_q <= c4_q.orig_g;
    ob_q <= c4_q.orig_b;

    res_q <= '{out_red: mix_out(pr_q, or_q), out_green: mix_out(pg_q, og_q),
               out_blue: mix_out(pb_q, ob_q)};
  end

  assign valid_o  = vld_q[5];
  assign result_o = res_q;
endmodule
`default_nettype wire

>>> dv/tb_night_vision_pixel_filter.sv
module tb_night_vision_pixel_filter;
  import nvpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // pipeline depth of the design (front, divider and back end stages), plus margin for the drain
  localparam int unsigned PipeDepth = 18;
  localparam int unsigned DrainCycles = 3 * PipeDepth;
  localparam int unsigned WatchdogLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  pixel_in_t   pixel_i = '0;
  logic        result_valid_o;
  pixel_out_t  result_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [4:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  night_vision_pixel_filter u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .pixel_i, .result_valid_o, .result_o,
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the configuration registers
  logic [12:0] img_width;
  logic [12:0] img_height;
  logic [31:0] frame_num;
  logic [8:0]  wt_red;
  logic [8:0]  wt_green;
  logic [8:0]  wt_blue;

  pixel_out_t  pending_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned item_count = 0;
  int unsigned idle_cycles = 0;
  bit          allow_gaps = 1'b1;

  function automatic int clamp_byte(int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  // blend from original toward filtered, division rounding toward minus infinity
  function automatic logic [7:0] blend_channel(int orig, int filt, int cov);
    int prod;
    int q;
    prod = (filt - orig) * cov;
    q = prod >= 0 ? (prod >>> 8) : -((-prod + 255) >>> 8);
    return 8'(clamp_byte(orig + q));
  endfunction

  function automatic pixel_out_t filter_pixel(pixel_in_t p);
    pixel_out_t o;
    int cov, lum, r, g, b, d, f;
    logic [31:0] h;
    longint cx, cy, m2, dx, dy, d2, dark, wd, ht;
    cov = p.coverage > 256 ? 256 : int'(p.coverage);
    lum = int'((32'(wt_red) * p.in_red + 32'(wt_green) * p.in_green
               + 32'(wt_blue) * p.in_blue) >> 8);
    g = clamp_byte(lum * 2);
    r = lum / 4;
    b = lum / 4;
    h = (32'(p.pixel_x) * HASH_MUL_X) ^ (32'(p.pixel_y) * HASH_MUL_Y)
        ^ (frame_num * HASH_MUL_FRAME);
    h ^= h >> 13;
    h *= HASH_MIX;
    h ^= h >> 15;
    d = int'(h % 41) - 20;
    r = clamp_byte(r + d);
    g = clamp_byte(g + d);
    b = clamp_byte(b + d);
    wd = img_width > NVPF_MAX_DIMENSION ? NVPF_MAX_DIMENSION : img_width;
    ht = img_height > NVPF_MAX_DIMENSION ? NVPF_MAX_DIMENSION : img_height;
    cx = wd / 2;
    cy = ht / 2;
    m2 = cx * cx + cy * cy;
    if (m2 < 1) m2 = 1;
    dx = longint'(p.pixel_x) - cx;
    dy = longint'(p.pixel_y) - cy;
    d2 = dx * dx + dy * dy;
    dark = (200 * d2) / m2;
    if (dark > 200) dark = 200;
    f = 255 - int'(dark);
    r = (r * f) >>> 8;
    g = (g * f) >>> 8;
    b = (b * f) >>> 8;
    o.out_red = blend_channel(p.in_red, r, cov);
    o.out_green = blend_channel(p.in_green, g, cov);
    o.out_blue = blend_channel(p.in_blue, b, cov);
    return o;
  endfunction

  // result checker and idle watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        result_count++;
        if (pending_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result %h", result_o);
        end else begin
          pixel_out_t want;
          want = pending_pixels.pop_front();
          if (result_o.out_red !== want.out_red || result_o.out_green !== want.out_green
              || result_o.out_blue !== want.out_blue) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected r%0d g%0d b%0d, got r%0d g%0d b%0d",
                       want.out_red, want.out_green, want.out_blue,
                       result_o.out_red, result_o.out_green, result_o.out_blue);
          end
        end
      end
      if (result_valid_o || (start_i && !busy_o) || psel_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no progress for %0d cycles", WatchdogLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // one write; the bus is left selected so the next write starts with its setup cycle
  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= {idx, 2'b00};
    pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    case (idx)
      REG_IMAGE_WIDTH:  img_width = value[12:0];
      REG_IMAGE_HEIGHT: img_height = value[12:0];
      REG_FRAME_NUMBER: frame_num = value;
      REG_WEIGHT_RED:   wt_red = value[8:0];
      REG_WEIGHT_GREEN: wt_green = value[8:0];
      REG_WEIGHT_BLUE:  wt_blue = value[8:0];
      default: ;
    endcase
  endtask

  task automatic bus_idle();
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
  endtask

  // wait until every expected pixel is back, then let the pipe empty
  task automatic drain_pipe();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_config(logic [12:0] w, logic [12:0] ht, logic [31:0] fr,
                            logic [8:0] wr, logic [8:0] wg, logic [8:0] wb);
    drain_pipe();
    reg_write(REG_IMAGE_WIDTH, 32'(w));
    reg_write(REG_IMAGE_HEIGHT, 32'(ht));
    reg_write(REG_FRAME_NUMBER, fr);
    reg_write(REG_WEIGHT_RED, 32'(wr));
    reg_write(REG_WEIGHT_GREEN, 32'(wg));
    reg_write(REG_WEIGHT_BLUE, 32'(wb));
    bus_idle();
    // derived terms settle after the last write
    repeat (4) @(posedge clk_i);
  endtask

  // send one pixel; the start stays high across back-to-back items
  task automatic send_pixel(pixel_in_t p);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (busy_o);
    pending_pixels.push_back(filter_pixel(p));
    item_count++;
  endtask

  task automatic end_burst();
    start_i <= 1'b0;
  endtask

  function automatic pixel_in_t make_pixel(int x, int y, int r, int g, int b, int cov);
    pixel_in_t p;
    p.pixel_x = 12'(x);
    p.pixel_y = 12'(y);
    p.in_red = 8'(r);
    p.in_green = 8'(g);
    p.in_blue = 8'(b);
    p.coverage = 9'(cov);
    return p;
  endfunction

  function automatic pixel_in_t random_pixel(int max_x, int max_y);
    pixel_in_t p;
    int c;
    p.pixel_x = 12'($urandom_range(0, max_x));
    p.pixel_y = 12'($urandom_range(0, max_y));
    p.in_red = 8'($urandom);
    p.in_green = 8'($urandom);
    p.in_blue = 8'($urandom);
    // coverage mostly full or zero, sometimes partial or oversized
    c = $urandom_range(0, 9);
    p.coverage = c < 4 ? 9'd256 : c == 4 ? 9'd0 : c == 5 ? 9'($urandom_range(257, 511))
                                            : 9'($urandom_range(1, 255));
    return p;
  endfunction

  // field extremes, coverage corners, pixels far outside the image, heavy weights, zero and oversized sizes
  task automatic test_directed();
    send_pixel(make_pixel(0, 0, 0, 0, 0, 256));
    send_pixel(make_pixel(4095, 4095, 255, 255, 255, 256));
    send_pixel(make_pixel(160, 120, 255, 255, 255, 256));
    send_pixel(make_pixel(160, 120, 200, 10, 90, 0));
    send_pixel(make_pixel(100, 50, 30, 140, 250, 511));
    send_pixel(make_pixel(100, 50, 30, 140, 250, 257));
    send_pixel(make_pixel(319, 239, 255, 0, 0, 128));
    send_pixel(make_pixel(0, 239, 0, 255, 0, 1));
    send_pixel(make_pixel(2730, 1365, 0, 0, 255, 255));
    send_pixel(make_pixel(1365, 2730, 170, 85, 170, 64));
    end_burst();
    // heavy weights push luminance past 255
    set_config(13'd320, 13'd240, 32'd7, 9'd256, 9'd256, 9'd256);
    send_pixel(make_pixel(160, 120, 255, 255, 255, 256));
    send_pixel(make_pixel(10, 200, 128, 255, 64, 256));
    end_burst();
    // zero and oversized dimensions
    set_config(13'd0, 13'd0, 32'hffff_ffff, 9'd0, 9'd0, 9'd0);
    send_pixel(make_pixel(0, 0, 77, 88, 99, 256));
    send_pixel(make_pixel(5, 3, 77, 88, 99, 256));
    end_burst();
    set_config(13'h1fff, 13'd4097, 32'h8000_0000, 9'd511, 9'd1, 9'd300);
    send_pixel(make_pixel(2048, 2048, 255, 255, 255, 256));
    send_pixel(make_pixel(0, 4095, 1, 2, 3, 200));
    send_pixel(make_pixel(4095, 0, 254, 253, 252, 256));
    end_burst();
  endtask

  task automatic test_random_configs();
    int w, ht;
    for (int phase = 0; phase < 8; phase++) begin
      w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 640);
      ht = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 480);
      set_config(13'(w), 13'(ht), $urandom, 9'($urandom), 9'($urandom), 9'($urandom));
      for (int i = 0; i < 75; i++)
        send_pixel($urandom_range(0, 4) == 0 ? random_pixel(4095, 4095)
                                              : random_pixel(w, ht));
      end_burst();
    end
  endtask

  // last part back to back at one item per clock
  task automatic test_full_rate();
    allow_gaps = 1'b0;
    set_config(13'd320, 13'd240, 32'd1234, 9'd77, 9'd150, 9'd29);
    for (int i = 0; i < 100; i++) send_pixel(random_pixel(330, 250));
    end_burst();
  endtask

  initial begin
    img_width = RST_IMAGE_WIDTH;
    img_height = RST_IMAGE_HEIGHT;
    frame_num = '0;
    wt_red = RST_WEIGHT_RED;
    wt_green = RST_WEIGHT_GREEN;
    wt_blue = RST_WEIGHT_BLUE;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    // reset values first, no writes yet
    for (int i = 0; i < 5; i++) send_pixel(random_pixel(320, 240));
    end_burst();
    test_directed();
    test_random_configs();
    test_full_rate();
    drain_pipe();
    $display("covered %0d pixels with %0d results over 13 register settings,", item_count,
             result_count);
    $display("including extreme weights, zero and oversized sizes, all coverage ranges");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
